### rtl/tpqm_pkg.sv
// Shared types and constants for the touch press qualifier and mapper.
// Depends on nothing; imported by every other file in the block.
package tpqm_pkg;

  localparam int RAW_BITS   = 12;
  localparam int SPAN_BITS  = 12;
  localparam int SIZE_W     = 13;
  localparam int MAX_SIZE   = 4096;
  localparam int TIME_W     = 32;
  localparam int SETTLE_W   = 16;
  localparam int PROD_W     = RAW_BITS + SPAN_BITS;
  localparam int STEP_CNT_W = $clog2(SPAN_BITS);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = (RAW_BITS > SETTLE_W) ? RAW_BITS : SETTLE_W;
  localparam int IN_DATA_W  = ((2 * RAW_BITS + TIME_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * SPAN_BITS + 7) / 8) * 8;

  localparam logic [RAW_BITS-1:0]  RAW_MIN_RST  = '0;
  localparam logic [RAW_BITS-1:0]  RAW_MAX_RST  = RAW_BITS'(4095 & ((1 << RAW_BITS) - 1));
  localparam logic [SIZE_W-1:0]    WIDTH_RST    = SIZE_W'(320);
  localparam logic [SIZE_W-1:0]    HEIGHT_RST   = SIZE_W'(240);
  localparam logic [2:0]           ORIENT_RST   = 3'd0;
  localparam logic [SETTLE_W-1:0]  SETTLE_RST   = SETTLE_W'(35);
  localparam logic [SIZE_W-1:0]    MAX_SIZE_V   = SIZE_W'(MAX_SIZE);
  localparam logic [SPAN_BITS-1:0] MAX_SPAN_V   = SPAN_BITS'(MAX_SIZE - 1);
  localparam logic [STEP_CNT_W-1:0] LAST_STEP   = STEP_CNT_W'(SPAN_BITS - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_MIN, REG_X_MAX, REG_Y_MIN, REG_Y_MAX,
    REG_WIDTH, REG_HEIGHT, REG_ORIENT, REG_SETTLE
  } tpqm_reg_t;

  typedef enum logic [2:0] {
    S_IDLE, S_EVAL, S_PREP, S_MUL, S_DIV, S_FIN
  } tpqm_state_t;

  typedef struct packed {
    logic capture;
    logic eval;
    logic prep;
    logic mul;
    logic step;
    logic load_out;
  } tpqm_cmd_t;

  typedef struct packed {
    logic event_hit;
    logic out_busy;
  } tpqm_sts_t;

  // screen size minus one, with size 0 taken as 1 and sizes above the maximum clipped
  function automatic logic [SPAN_BITS-1:0] eff_span(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] m;
    begin
      m = s - SIZE_W'(1);
      if (s == '0) begin
        eff_span = '0;
      end else if (s > MAX_SIZE_V) begin
        eff_span = MAX_SPAN_V;
      end else begin
        eff_span = m[SPAN_BITS-1:0];
      end
    end
  endfunction

endpackage

### rtl/tpqm_axis.sv
// One axis of the mapper: clamp, offset, multiply by span, restoring divide.
// Depends on tpqm_pkg; instanced twice by tpqm_datapath.
module tpqm_axis
  import tpqm_pkg::*;
(
  input  logic                 clk,
  input  tpqm_cmd_t            cmd,
  input  logic [RAW_BITS-1:0]  v,
  input  logic [RAW_BITS-1:0]  lo,
  input  logic [RAW_BITS-1:0]  hi,
  input  logic [SPAN_BITS-1:0] span,
  input  logic                 inv,
  output logic [SPAN_BITS-1:0] result
);

  logic [RAW_BITS-1:0]  off_r, den_r, rem_r;
  logic [SPAN_BITS-1:0] span_r, quo_r;
  logic                 empty_r, inv_r;

  logic [RAW_BITS-1:0]  vc;
  logic [RAW_BITS:0]    trial, diff;
  logic                 ge;
  logic [SPAN_BITS-1:0] q;

  always_comb begin
    if (v < lo) begin
      vc = lo;
    end else if (v > hi) begin
      vc = hi;
    end else begin
      vc = v;
    end
    trial  = {rem_r, quo_r[SPAN_BITS-1]};
    diff   = trial - {1'b0, den_r};
    ge     = (trial >= {1'b0, den_r});
    q      = empty_r ? '0 : quo_r;
    result = inv_r ? (span_r - q) : q;
  end

  // quotient builds up in the low word as it shifts out the product's low bits
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      empty_r <= (hi <= lo);
      off_r   <= vc - lo;
      den_r   <= hi - lo;
      span_r  <= span;
      inv_r   <= inv;
    end
    if (cmd.mul) begin
      {rem_r, quo_r} <= PROD_W'(off_r) * PROD_W'(span_r);
    end else if (cmd.step) begin
      rem_r <= ge ? diff[RAW_BITS-1:0] : trial[RAW_BITS-1:0];
      quo_r <= {quo_r[SPAN_BITS-2:0], ge};
    end
  end

endmodule

### rtl/tpqm_datapath.sv
// Datapath: config registers, press tracking, two axis units and the output register.
// Depends on tpqm_pkg and tpqm_axis; driven by tpqm_ctrl commands.
module tpqm_datapath
  import tpqm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  tpqm_cmd_t             cmd,
  output tpqm_sts_t             sts,
  input  logic                  in_contact,
  input  logic [RAW_BITS-1:0]   in_raw_x,
  input  logic [RAW_BITS-1:0]   in_raw_y,
  input  logic [TIME_W-1:0]     in_now_ms,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SPAN_BITS-1:0]  out_screen_x,
  output logic [SPAN_BITS-1:0]  out_screen_y
);

  logic [RAW_BITS-1:0] x_min_r, x_max_r, y_min_r, y_max_r;
  logic [SIZE_W-1:0]   width_r, height_r;
  logic [2:0]          orient_r;
  logic [SETTLE_W-1:0] settle_r;

  logic                contact_r;
  logic [RAW_BITS-1:0] rx_r, ry_r;
  logic [TIME_W-1:0]   now_r;

  logic                active_r, active_nxt;
  logic                reported_r, reported_nxt;
  logic [TIME_W-1:0]   start_r;

  logic                 out_valid_r, out_valid_nxt;
  logic [SPAN_BITS-1:0] out_x_r, out_y_r;

  logic [TIME_W-1:0]    held;
  logic                 hit;
  logic [RAW_BITS-1:0]  ax_v, ay_v;
  logic [SPAN_BITS-1:0] ax_res, ay_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_min_r  <= RAW_MIN_RST;
      x_max_r  <= RAW_MAX_RST;
      y_min_r  <= RAW_MIN_RST;
      y_max_r  <= RAW_MAX_RST;
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      orient_r <= ORIENT_RST;
      settle_r <= SETTLE_RST;
    end else if (cfg_we) begin
      case (tpqm_reg_t'(cfg_index))
        REG_X_MIN:  x_min_r  <= cfg_wdata[RAW_BITS-1:0];
        REG_X_MAX:  x_max_r  <= cfg_wdata[RAW_BITS-1:0];
        REG_Y_MIN:  y_min_r  <= cfg_wdata[RAW_BITS-1:0];
        REG_Y_MAX:  y_max_r  <= cfg_wdata[RAW_BITS-1:0];
        REG_WIDTH:  width_r  <= SIZE_W'(cfg_wdata);
        REG_HEIGHT: height_r <= SIZE_W'(cfg_wdata);
        REG_ORIENT: orient_r <= cfg_wdata[2:0];
        REG_SETTLE: settle_r <= cfg_wdata[SETTLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      contact_r <= in_contact;
      rx_r      <= in_raw_x;
      ry_r      <= in_raw_y;
      now_r     <= in_now_ms;
    end
  end

  // press qualification
  always_comb begin
    held         = now_r - start_r;
    hit          = 1'b0;
    active_nxt   = active_r;
    reported_nxt = reported_r;
    if (!contact_r) begin
      active_nxt   = 1'b0;
      reported_nxt = 1'b0;
    end else if (!active_r) begin
      active_nxt   = 1'b1;
      reported_nxt = 1'b0;
    end else if (!reported_r && (held >= TIME_W'(settle_r))) begin
      hit          = 1'b1;
      reported_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      reported_r <= 1'b0;
      start_r    <= '0;
    end else if (cmd.eval) begin
      active_r   <= active_nxt;
      reported_r <= reported_nxt;
      if (contact_r && !active_r) begin
        start_r <= now_r;
      end
    end
  end

  assign ax_v = orient_r[0] ? ry_r : rx_r;
  assign ay_v = orient_r[0] ? rx_r : ry_r;

  tpqm_axis u_axis_x (
    .clk    (clk),
    .cmd    (cmd),
    .v      (ax_v),
    .lo     (x_min_r),
    .hi     (x_max_r),
    .span   (eff_span(width_r)),
    .inv    (orient_r[1]),
    .result (ax_res)
  );

  tpqm_axis u_axis_y (
    .clk    (clk),
    .cmd    (cmd),
    .v      (ay_v),
    .lo     (y_min_r),
    .hi     (y_max_r),
    .span   (eff_span(height_r)),
    .inv    (orient_r[2]),
    .result (ay_res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_x_r <= ax_res;
      out_y_r <= ay_res;
    end
  end

  assign sts.event_hit = hit;
  assign sts.out_busy  = out_valid_r && !out_ready;
  assign out_valid     = out_valid_r;
  assign out_screen_x  = out_x_r;
  assign out_screen_y  = out_y_r;

endmodule

### rtl/tpqm_ctrl.sv
// Controller: sequences capture, qualification, mapping and the divider steps.
// Depends on tpqm_pkg; commands tpqm_datapath.
module tpqm_ctrl
  import tpqm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  tpqm_sts_t sts,
  output tpqm_cmd_t cmd
);

  tpqm_state_t           state_r, state_nxt;
  logic [STEP_CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = sts.event_hit ? S_PREP : S_IDLE;
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + STEP_CNT_W'(1);
        if (cnt_r == LAST_STEP) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_accept_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_EVAL))
    else $error("accepted beat not followed by evaluation");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !sts.out_busy)
    else $error("output register overwritten while held");

  a_fin_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |-> ($past(state_r) == S_DIV || $past(state_r) == S_FIN))
    else $error("result stage entered without divider pass");

  a_div_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DIV) && (state_nxt == S_FIN)) |-> (cnt_r == LAST_STEP))
    else $error("divider left early");

endmodule

### rtl/touch_press_qualify_and_map_top.sv
// Top level of the touch press qualifier and screen mapper.
// Depends on tpqm_pkg, tpqm_ctrl, tpqm_datapath (and tpqm_axis below it).
//
//  channel | direction | tdata (low bit up)                 | tuser
//  in_     | slave     | raw_x[11:0] raw_y[23:12] now_ms[55:24] | contact
//  out_    | master    | screen_x[11:0] screen_y[23:12]     | -
//  cfg_    | write     | cfg_wdata, index per register list | -
//
// A poll that gives no event passes through the accept beat and the evaluation state.
// A poll that gives an event passes through accept, evaluation, preparation, multiply,
// the 12 restoring-divider steps (both axes side by side) and the result load.
// Reset is synchronous, active low, and leaves the block ready with no press active.
// A stalled output holds the result register; the next poll is still taken and waits
// in its final stage only if it too produces an event.
module touch_press_qualify_and_map_top
  import tpqm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // raw_x, raw_y, now_ms
  input  logic                  in_tuser,   // contact
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // screen_x, screen_y
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  tpqm_cmd_t            cmd;
  tpqm_sts_t            sts;
  logic [SPAN_BITS-1:0] sx, sy;

  tpqm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tpqm_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_contact   (in_tuser),
    .in_raw_x     (in_tdata[RAW_BITS-1:0]),
    .in_raw_y     (in_tdata[2*RAW_BITS-1:RAW_BITS]),
    .in_now_ms    (in_tdata[2*RAW_BITS+TIME_W-1:2*RAW_BITS]),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_screen_x (sx),
    .out_screen_y (sy)
  );

  assign out_tdata = OUT_DATA_W'({sy, sx});

endmodule
